[rtl/rr_pkg.sv]
// Shared types for the fraction reduction unit.
package rr_pkg;

    // Sequencer steps of the reduction unit
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG_NUM,
        ST_MAG_DEN,
        ST_ZERO_CHK,
        ST_STRIP,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_SIGN
    } t_state;

endpackage

[rtl/rr_sub.sv]
// Shared subtract and compare unit of the fraction reduction unit.
module rr_sub #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow
);

    logic [WIDTH:0] full;

    // Borrow set means i_a is below i_b
    assign full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = full[WIDTH-1:0];
    assign o_borrow = full[WIDTH];

endmodule

[rtl/rational_reduce_unit.sv]
// Fraction reduction unit: brings a signed fraction to lowest terms.
//
// Usage: drive i_numerator_in and i_denominator_in and raise start while busy
// is low; the item is taken at that clock edge and busy goes high on the next
// cycle. One item is worked on at a time, and start is ignored while busy.
// The result appears on o_numerator_out and o_denominator_out for exactly one
// cycle, marked by o_valid, in the same cycle that busy drops; the receiver
// must take it then, as it cannot hold results off.
// Steps: one shared subtractor serves the magnitude, GCD, division and sign
// steps. The magnitudes are formed first, then a check for a zero operand
// (such an item goes straight to the sign step); common factors of two are
// stripped, the binary GCD loop runs (shift, subtract or swap, one per cycle),
// two restoring divisions run bit-serially, and a last step applies the sign.
// Reset (synchronous, active low) returns the sequencer to idle and clears
// o_valid; any item in progress is dropped.
module rational_reduce_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_numerator_in,
    input  logic [DATA_WIDTH-1:0] i_denominator_in,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_numerator_out,
    output logic [DATA_WIDTH-2:0] o_denominator_out
);

    localparam int SW = DATA_WIDTH + 1;
    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] CNT_MAX = CW'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    rr_pkg::t_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_na, n_na;
    logic [DATA_WIDTH-1:0] r_nb, n_nb;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_num_neg, n_num_neg;
    logic                  r_den_neg, n_den_neg;
    logic                  r_valid, n_valid;
    logic [DATA_WIDTH-1:0] r_num_out, n_num_out;
    logic [DATA_WIDTH-2:0] r_den_out, n_den_out;

    logic [SW-1:0] sub_a, sub_b, sub_diff;
    logic          sub_borrow;
    logic          neg;

    rr_sub #(.WIDTH(SW)) u_sub (
        .i_a      (sub_a),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    assign busy              = (r_state != rr_pkg::ST_IDLE);
    assign o_valid           = r_valid;
    assign o_numerator_out   = r_num_out;
    assign o_denominator_out = r_den_out;

    assign neg = (r_num_neg ^ r_den_neg) && (|r_na);

    // Operand selection for the shared subtractor
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        unique case (r_state)
            rr_pkg::ST_MAG_NUM: sub_b = {1'b0, r_na};
            rr_pkg::ST_MAG_DEN: sub_b = {1'b0, r_nb};
            rr_pkg::ST_GCD: begin
                sub_a = {1'b0, r_y};
                sub_b = {1'b0, r_x};
            end
            rr_pkg::ST_DIV_NUM: begin
                sub_a = {r_rem, r_na[DATA_WIDTH-1]};
                sub_b = {1'b0, r_x};
            end
            rr_pkg::ST_DIV_DEN: begin
                sub_a = {r_rem, r_nb[DATA_WIDTH-1]};
                sub_b = {1'b0, r_x};
            end
            rr_pkg::ST_SIGN: sub_b = {1'b0, r_na};
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_na      = r_na;
        n_nb      = r_nb;
        n_x       = r_x;
        n_y       = r_y;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_num_neg = r_num_neg;
        n_den_neg = r_den_neg;
        n_valid   = 1'b0;
        n_num_out = r_num_out;
        n_den_out = r_den_out;
        unique case (r_state)
            rr_pkg::ST_IDLE: begin
                if (start) begin
                    n_na      = i_numerator_in;
                    n_nb      = i_denominator_in;
                    n_num_neg = i_numerator_in[DATA_WIDTH-1];
                    n_den_neg = i_denominator_in[DATA_WIDTH-1];
                    n_state   = rr_pkg::ST_MAG_NUM;
                end
            end
            rr_pkg::ST_MAG_NUM: begin
                if (r_num_neg) begin
                    n_na = sub_diff[DATA_WIDTH-1:0];
                end
                n_state = rr_pkg::ST_MAG_DEN;
            end
            rr_pkg::ST_MAG_DEN: begin
                if (r_den_neg) begin
                    n_nb = sub_diff[DATA_WIDTH-1:0];
                end
                n_state = rr_pkg::ST_ZERO_CHK;
            end
            rr_pkg::ST_ZERO_CHK: begin
                // A zero operand leaves 0/0, 0/1 or 1/0 in magnitude
                if (r_na == '0 || r_nb == '0) begin
                    n_na    = '0;
                    n_nb    = '0;
                    n_na[0] = |r_na;
                    n_nb[0] = |r_nb;
                    n_state = rr_pkg::ST_SIGN;
                end else begin
                    n_state = rr_pkg::ST_STRIP;
                end
            end
            rr_pkg::ST_STRIP: begin
                // Drop common factors of two from both; the quotients are unchanged
                if (!r_na[0] && !r_nb[0]) begin
                    n_na = r_na >> 1;
                    n_nb = r_nb >> 1;
                end else begin
                    n_x     = r_na;
                    n_y     = r_nb;
                    n_state = rr_pkg::ST_GCD;
                end
            end
            rr_pkg::ST_GCD: begin
                priority if (r_y == '0) begin
                    n_rem   = '0;
                    n_cnt   = CNT_MAX;
                    n_state = rr_pkg::ST_DIV_NUM;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (sub_borrow) begin
                    // Keep the smaller odd value in x
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_y = sub_diff[DATA_WIDTH-1:0];
                end
            end
            rr_pkg::ST_DIV_NUM: begin
                n_rem = sub_borrow ? sub_a[DATA_WIDTH-1:0] : sub_diff[DATA_WIDTH-1:0];
                n_na  = {r_na[DATA_WIDTH-2:0], !sub_borrow};
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_cnt   = CNT_MAX;
                    n_state = rr_pkg::ST_DIV_DEN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            rr_pkg::ST_DIV_DEN: begin
                n_rem = sub_borrow ? sub_a[DATA_WIDTH-1:0] : sub_diff[DATA_WIDTH-1:0];
                n_nb  = {r_nb[DATA_WIDTH-2:0], !sub_borrow};
                if (r_cnt == '0) begin
                    n_state = rr_pkg::ST_SIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            rr_pkg::ST_SIGN: begin
                // Negate or saturate the numerator, saturate the denominator
                if (neg) begin
                    n_num_out = sub_diff[DATA_WIDTH-1:0];
                end else if (r_na[DATA_WIDTH-1]) begin
                    n_num_out = MAX_POS;
                end else begin
                    n_num_out = r_na;
                end
                n_den_out = r_nb[DATA_WIDTH-1] ? MAX_POS[DATA_WIDTH-2:0]
                                               : r_nb[DATA_WIDTH-2:0];
                n_valid   = 1'b1;
                n_state   = rr_pkg::ST_IDLE;
            end
            default: begin
                n_state = rr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rr_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_na      <= n_na;
        r_nb      <= n_nb;
        r_x       <= n_x;
        r_y       <= n_y;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_num_neg <= n_num_neg;
        r_den_neg <= n_den_neg;
        r_num_out <= n_num_out;
        r_den_out <= n_den_out;
    end

endmodule

[rtl/rr_checker.sv]
// Port checker for the fraction reduction unit, bound to the top level.
module rr_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DATA_WIDTH-1:0] o_numerator_out,
    input logic [DATA_WIDTH-2:0] o_denominator_out
);

    // A taken item keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("unit not busy after taking an item");

    // A result is shown whenever work ends
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("work ended without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && !$past(o_valid))
        else $error("result strobe while busy or held too long");

    // A zero denominator comes only with 0, +1 or -1 above it
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_denominator_out == '0 |->
            o_numerator_out == '0 || o_numerator_out == DATA_WIDTH'(1) ||
            o_numerator_out == '1)
        else $error("zero denominator with a reduced numerator");

endmodule

bind rational_reduce_unit rr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_numerator_out   (o_numerator_out),
    .o_denominator_out (o_denominator_out)
);
